// ----- rtl/slpc_pkg.sv -----
// ----------------------------------------------------------------------------
// slpc_pkg
// Shared types and constants for the short/long press classifier.
// ----------------------------------------------------------------------------
package slpc_pkg;

	localparam int NUM_BUTTONS   = 2;
	localparam int COUNT_WIDTH   = 16;
	localparam int THRESH_W      = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 16;

	localparam logic [THRESH_W-1:0] SHORT_MIN_RESET = 16'd50;
	localparam logic [THRESH_W-1:0] LONG_RESET      = 16'd500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_MIN = 1'b0,
		REG_LONG      = 1'b1
	} slpc_reg_t;

	typedef struct packed {
		logic short_ev;
		logic long_ev;
	} slpc_event_t;

	typedef struct packed {
		logic [THRESH_W-1:0] short_min;
		logic [THRESH_W-1:0] long_thr;
	} slpc_thresh_t;

endpackage

// ----- rtl/slpc_if.sv -----
// ----------------------------------------------------------------------------
// slpc_if
// Valid/ready channels for tick words and press-event words.
// ----------------------------------------------------------------------------
interface slpc_in_if import slpc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [NUM_BUTTONS-1:0] button_levels;

	modport source (output valid, output button_levels, input ready);
	modport sink (input valid, input button_levels, output ready);
endinterface

interface slpc_out_if import slpc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [NUM_BUTTONS-1:0] short_press_mask;
	logic [NUM_BUTTONS-1:0] long_press_mask;

	modport source (output valid, output short_press_mask, output long_press_mask,
		input ready);
	modport sink (input valid, input short_press_mask, input long_press_mask,
		output ready);
endinterface

// ----- rtl/slpc_button_cell.sv -----
// ----------------------------------------------------------------------------
// slpc_button_cell
// Held-time counter and long latch of one button; classifies one tick.
// ----------------------------------------------------------------------------
module slpc_button_cell import slpc_pkg::*; #(
	parameter int COUNT_W = COUNT_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         advance,
	input  logic         pressed,
	input  slpc_thresh_t thresh,
	output slpc_event_t  event_o
);

	localparam int CMP_W = (COUNT_W > THRESH_W) ? COUNT_W : THRESH_W;
	localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};

	logic [COUNT_W-1:0] count_q;
	logic               latched_q;
	logic [COUNT_W-1:0] count_inc;
	logic [CMP_W-1:0]   count_ext;
	logic [CMP_W-1:0]   inc_ext;
	logic [CMP_W-1:0]   short_ext;
	logic [CMP_W-1:0]   long_ext;

	always_comb begin
		count_inc = (count_q == CNT_MAX) ? count_q : count_q + 1'b1;
		count_ext = CMP_W'(count_q);
		inc_ext   = CMP_W'(count_inc);
		short_ext = CMP_W'(thresh.short_min);
		long_ext  = CMP_W'(thresh.long_thr);
		event_o.long_ev  = pressed && !latched_q && (inc_ext > long_ext);
		event_o.short_ev = !pressed && (count_ext >= short_ext) && (count_ext < long_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			latched_q <= 1'b0;
		end else if (advance) begin
			if (pressed) begin
				count_q   <= count_inc;
				latched_q <= latched_q | event_o.long_ev;
			end else begin
				count_q   <= '0;
				latched_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/short_long_press_classifier.sv -----
// ----------------------------------------------------------------------------
// short_long_press_classifier
// Classifies button holds into short and long press events, one tick a word.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | handshake
//  in_ch   | in  | button_levels                        | valid/ready
//  out_ch  | out | short_press_mask, long_press_mask    | valid/ready
//  cfg     | in  | cfg_index, cfg_wdata                 | cfg_we, no back-pressure
//
//  One word per cycle while the output is not stalled; a taken tick word passes
//  the input register, then the result register after the per-button compares.
//  Reset clears the counters, latches, valid flags and restores the thresholds.
//  A stalled output holds both stages; input ready falls only when both are full.
// ----------------------------------------------------------------------------
module short_long_press_classifier import slpc_pkg::*; #(
	parameter int COUNT_W = COUNT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	slpc_in_if.sink               in_ch,
	slpc_out_if.source            out_ch
);

	slpc_thresh_t           thresh_q;
	logic                   valid_s1;
	logic [NUM_BUTTONS-1:0] levels_s1;
	logic                   out_valid_q;
	logic [NUM_BUTTONS-1:0] short_q;
	logic [NUM_BUTTONS-1:0] long_q;
	logic                   advance;
	logic                   take;
	slpc_event_t            events [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] short_next;
	logic [NUM_BUTTONS-1:0] long_next;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign take        = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !valid_s1 || !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q.short_min <= SHORT_MIN_RESET;
			thresh_q.long_thr  <= LONG_RESET;
		end else if (cfg_we) begin
			unique case (slpc_reg_t'(cfg_index))
				REG_SHORT_MIN: thresh_q.short_min <= cfg_wdata[THRESH_W-1:0];
				REG_LONG:      thresh_q.long_thr  <= cfg_wdata[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ch.ready) valid_s1 <= in_ch.valid;
			if (!out_valid_q || out_ch.ready) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) levels_s1 <= in_ch.button_levels;
		if (advance) begin
			short_q <= short_next;
			long_q  <= long_next;
		end
	end

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
		slpc_button_cell #(.COUNT_W(COUNT_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.pressed (!levels_s1[b]),
			.thresh  (thresh_q),
			.event_o (events[b])
		);
		assign short_next[b] = events[b].short_ev;
		assign long_next[b]  = events[b].long_ev;
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.short_press_mask = short_q;
	assign out_ch.long_press_mask  = long_q;

endmodule

// ----- rtl/slpc_checker.sv -----
// ----------------------------------------------------------------------------
// slpc_checker
// Port-level checks of the press classifier, bound to the top level.
// ----------------------------------------------------------------------------
module slpc_checker import slpc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [NUM_BUTTONS-1:0] short_mask,
	input logic [NUM_BUTTONS-1:0] long_mask
);

	logic [NUM_BUTTONS-1:0] prev_long_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_long_q <= '0;
		end else if (out_valid && out_ready) begin
			prev_long_q <= long_mask;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(long_mask) && $stable(short_mask))
		else $error("output word changed while stalled");

	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (short_mask & long_mask) == '0)
		else $error("button reported short and long in one word");

	a_long_once: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> (long_mask & prev_long_q) == '0)
		else $error("long press reported on consecutive words");

	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

endmodule

bind short_long_press_classifier slpc_checker u_slpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.short_mask (out_ch.short_press_mask),
	.long_mask  (out_ch.long_press_mask)
);

// ----- dv/press_event_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// press_event_checker
// Watches the tick and event channels and the threshold write port, tracks
// per-button hold counters and long latches, and compares every event word
// with the masks predicted for the tick word that caused it.
// ----------------------------------------------------------------------------
module press_event_checker import slpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	slpc_in_if                    in_ch,
	slpc_out_if                   out_ch,
	output int                    fail_count,
	output int                    events_pending
);

	typedef struct packed {
		logic [NUM_BUTTONS-1:0] short_mask;
		logic [NUM_BUTTONS-1:0] long_mask;
	} press_masks_t;

	logic [THRESH_W-1:0]    short_min;
	logic [THRESH_W-1:0]    long_thr;
	logic [COUNT_WIDTH-1:0] held_count [NUM_BUTTONS];
	logic                   long_latched [NUM_BUTTONS];
	press_masks_t           expected_events [$];
	int                     event_index;

	function automatic press_masks_t classify_tick(input logic [NUM_BUTTONS-1:0] levels);
		press_masks_t res;
		res = '0;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			if (!levels[b]) begin
				if (held_count[b] != '1) begin
					held_count[b] = held_count[b] + 1'b1;
				end
				if (held_count[b] > long_thr && !long_latched[b]) begin
					long_latched[b] = 1'b1;
					res.long_mask[b] = 1'b1;
				end
			end else begin
				if (held_count[b] >= short_min && held_count[b] < long_thr) begin
					res.short_mask[b] = 1'b1;
				end
				held_count[b] = '0;
				long_latched[b] = 1'b0;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		press_masks_t want;
		if (!arst_n) begin
			short_min = SHORT_MIN_RESET;
			long_thr = LONG_RESET;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				held_count[b] = '0;
				long_latched[b] = 1'b0;
			end
			expected_events.delete();
			event_index = 0;
		end else begin
			if (cfg_we) begin
				case (slpc_reg_t'(cfg_index))
					REG_SHORT_MIN: short_min = cfg_wdata;
					REG_LONG:      long_thr = cfg_wdata;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				expected_events.push_back(classify_tick(in_ch.button_levels));
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_events.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("event word %0d: none expected, got short=%b long=%b",
							event_index, out_ch.short_press_mask, out_ch.long_press_mask);
					end
				end else begin
					want = expected_events.pop_front();
					if (out_ch.short_press_mask !== want.short_mask ||
						out_ch.long_press_mask !== want.long_mask) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("event word %0d: expected short=%b long=%b, got short=%b long=%b",
								event_index, want.short_mask, want.long_mask,
								out_ch.short_press_mask, out_ch.long_press_mask);
						end
					end
				end
				event_index++;
			end
		end
		events_pending = expected_events.size();
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick words into the press classifier under varying thresholds and
// handshake pressure: a reset-threshold hold, a directed pattern, and random
// press/release runs sized around the thresholds. The checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench import slpc_pkg::*;;

	localparam int QUIET_LIMIT = 1000;
	localparam int RANDOM_TICKS = 41;

	localparam logic [NUM_BUTTONS-1:0] DIRECTED_TICKS [20] = '{
		2'b11, 2'b00, 2'b00, 2'b11,
		2'b10, 2'b10, 2'b10, 2'b10, 2'b10,
		2'b01, 2'b01, 2'b01, 2'b01, 2'b11,
		2'b00, 2'b11,
		2'b00, 2'b00, 2'b00, 2'b11
	};
	localparam int SHORT_SET [8] = '{3, 0, 0, 5, 1, 10, 2, 4};
	localparam int LONG_SET  [8] = '{8, 5, 0, 5, 2, 4, 12, 20};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fail_count;
	int                    events_pending;
	int                    send_idle_pct;
	int                    recv_idle_pct;
	int                    cur_short;
	int                    cur_long;
	int                    quiet_cycles;
	int                    run_left [NUM_BUTTONS];
	bit                    run_pressed [NUM_BUTTONS];

	slpc_in_if  in_ch ();
	slpc_out_if out_ch ();

	short_long_press_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	press_event_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_ch          (in_ch),
		.out_ch         (out_ch),
		.fail_count     (fail_count),
		.events_pending (events_pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic drive_tick(input logic [NUM_BUTTONS-1:0] levels);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.button_levels <= levels;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (events_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_thresholds(input int short_val, input int long_val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_SHORT_MIN;
		cfg_wdata <= CFG_DATA_W'(short_val);
		@(negedge clk);
		cfg_index <= REG_LONG;
		cfg_wdata <= CFG_DATA_W'(long_val);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_short = short_val;
		cur_long = long_val;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			run_left[b] = 0;
			run_pressed[b] = 1'b0;
		end
	endtask

	// press runs land near the thresholds; a few ticks are pure noise
	function automatic logic [NUM_BUTTONS-1:0] pick_levels();
		logic [NUM_BUTTONS-1:0] lv;
		int                     len;
		if ($urandom_range(99) < 8) begin
			return NUM_BUTTONS'($urandom);
		end
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			if (run_left[b] == 0) begin
				run_pressed[b] = !run_pressed[b];
				if (run_pressed[b]) begin
					case ($urandom_range(7))
						0: len = cur_short - 1;
						1: len = cur_short;
						2: len = cur_short + 1;
						3: len = cur_long - 1;
						4: len = cur_long;
						5: len = cur_long + 1;
						6: len = cur_long + 2;
						default: len = $urandom_range(cur_long + 3, 1);
					endcase
					run_left[b] = (len < 1) ? 1 : len;
				end else begin
					run_left[b] = $urandom_range(3, 1);
				end
			end
			run_left[b]--;
			lv[b] = !run_pressed[b];
		end
		return lv;
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SHORT_MIN;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.button_levels = '1;
		send_idle_pct = 11;
		recv_idle_pct = 54;
		cur_short = SHORT_MIN_RESET;
		cur_long = LONG_RESET;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// hold both past the reset short threshold, then release
		repeat (51) drive_tick(2'b00);
		drive_tick(2'b11);

		set_thresholds(2, 4);
		foreach (DIRECTED_TICKS[i]) drive_tick(DIRECTED_TICKS[i]);

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 54;
				recv_idle_pct = 11;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			foreach (SHORT_SET[s]) begin
				set_thresholds(SHORT_SET[s], LONG_SET[s]);
				repeat (RANDOM_TICKS) drive_tick(pick_levels());
			end
		end

		in_ch.valid <= 1'b0;
		while (events_pending != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/slpc_pkg.sv
rtl/slpc_if.sv
rtl/slpc_button_cell.sv
rtl/short_long_press_classifier.sv
rtl/slpc_checker.sv
dv/press_event_checker.sv
dv/testbench.sv
